// ===== rtl/rdpid_pkg.sv =====
// Shared types and constants for the roll damper PID block.
// Used by rdpid_ctrl, rdpid_dp and roll_damper_pid_top; no dependencies.
package rdpid_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_RATE_GAIN      = 3'd0;
  localparam logic [2:0] REG_ANGLE_GAIN     = 3'd1;
  localparam logic [2:0] REG_INTEGRAL_GAIN  = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [2:0] REG_TIME_STEP      = 3'd4;

  // Fixed-point constants
  localparam int unsigned ANGLE_TO_RAD_Q = 46851;  // pi/18000 in Q28
  localparam int          DAMP_LIMIT     = 4500;
  localparam int unsigned MIN_AIRSPEED   = 1000;

  // Payload widths
  localparam int CFG_W   = 21;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 16;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_ANG,
    ST_INC,
    ST_ACC,
    ST_T2,
    ST_T3,
    ST_FIN,
    ST_DONE
  } rdpid_state_t;

  // Datapath step selector
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_CONV,
    STEP_ANG,
    STEP_INC,
    STEP_ACC,
    STEP_T2,
    STEP_T3,
    STEP_FIN
  } dp_step_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    dp_step_t step;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_active;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/rdpid_ctrl.sv =====
// Sequencing state machine for the roll damper PID block.
// Depends on rdpid_pkg; drives rdpid_dp through dp_cmd_t.
module rdpid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdpid_pkg::dp_sts_t sts,
  output rdpid_pkg::dp_cmd_t cmd
);

  rdpid_pkg::rdpid_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdpid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.step     = rdpid_pkg::STEP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      rdpid_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_active ? rdpid_pkg::ST_CONV : rdpid_pkg::ST_DONE;
        end
      end
      rdpid_pkg::ST_CONV: begin
        cmd.step   = rdpid_pkg::STEP_CONV;
        state_next = rdpid_pkg::ST_ANG;
      end
      rdpid_pkg::ST_ANG: begin
        cmd.step   = rdpid_pkg::STEP_ANG;
        state_next = rdpid_pkg::ST_INC;
      end
      rdpid_pkg::ST_INC: begin
        cmd.step   = rdpid_pkg::STEP_INC;
        state_next = rdpid_pkg::ST_ACC;
      end
      rdpid_pkg::ST_ACC: begin
        cmd.step   = rdpid_pkg::STEP_ACC;
        state_next = rdpid_pkg::ST_T2;
      end
      rdpid_pkg::ST_T2: begin
        cmd.step   = rdpid_pkg::STEP_T2;
        state_next = rdpid_pkg::ST_T3;
      end
      rdpid_pkg::ST_T3: begin
        cmd.step   = rdpid_pkg::STEP_T3;
        state_next = rdpid_pkg::ST_FIN;
      end
      rdpid_pkg::ST_FIN: begin
        cmd.step   = rdpid_pkg::STEP_FIN;
        state_next = rdpid_pkg::ST_DONE;
      end
      rdpid_pkg::ST_DONE: begin
        // Hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rdpid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdpid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rdpid_dp.sv =====
// Datapath of the roll damper PID block: config registers, shared multiplier,
// integrator, term accumulator and output register. Depends on rdpid_pkg.
module rdpid_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [rdpid_pkg::CFG_W-1:0]  cfg_data,
  input  logic [rdpid_pkg::IN_W-1:0]   in_data,
  input  logic                         in_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rdpid_pkg::OUT_W-1:0]  out_data,
  input  rdpid_pkg::dp_cmd_t           cmd,
  output rdpid_pkg::dp_sts_t           sts
);

  // Configuration registers
  logic signed [13:0] rate_gain;
  logic signed [12:0] angle_gain;
  logic signed [9:0]  integral_gain;
  logic        [13:0] integral_limit;
  logic        [20:0] time_step;

  // Captured item
  logic               active;
  logic signed [15:0] roll_rate;
  logic signed [15:0] roll_angle;
  logic signed [13:0] pilot;

  // Working registers
  logic signed [15:0] angle_rad;   // Q12 radians
  logic signed [27:0] integral;    // Q20 rad*s
  logic signed [49:0] prod;
  logic signed [23:0] dsum;

  // Combinational values
  logic               in_speed_valid;
  logic        [15:0] in_airspeed;
  logic signed [27:0] op_x;
  logic signed [21:0] op_y;
  logic signed [49:0] ang_round;
  logic signed [49:0] inc_round;
  logic signed [24:0] inc;
  logic signed [28:0] acc_sum;
  logic signed [28:0] lim;
  logic signed [28:0] acc_clamp;
  logic signed [23:0] term;
  logic signed [13:0] damp;
  logic signed [14:0] cmd_val;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_gain      <= -14'sd3200;
      angle_gain     <= -13'sd800;
      integral_gain  <= -10'sd200;
      integral_limit <= 14'd3072;
      time_step      <= 21'd2621;
    end else if (cfg_we) begin
      case (cfg_index)
        rdpid_pkg::REG_RATE_GAIN:      rate_gain      <= $signed(cfg_data[13:0]);
        rdpid_pkg::REG_ANGLE_GAIN:     angle_gain     <= $signed(cfg_data[12:0]);
        rdpid_pkg::REG_INTEGRAL_GAIN:  integral_gain  <= $signed(cfg_data[9:0]);
        rdpid_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[13:0];
        rdpid_pkg::REG_TIME_STEP:      time_step      <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // Airspeed gating of the incoming transaction
  assign in_speed_valid = in_data[0];
  assign in_airspeed    = in_data[16:1];
  assign sts.in_active  = in_speed_valid &&
                          (in_airspeed >= 16'(rdpid_pkg::MIN_AIRSPEED));
  assign sts.out_free   = !out_valid || out_ready;

  // Select multiplier operands for each step
  always_comb begin
    op_x = '0;
    op_y = '0;
    case (cmd.step)
      rdpid_pkg::STEP_CONV: begin
        op_x = 28'(roll_angle);
        op_y = 22'(rdpid_pkg::ANGLE_TO_RAD_Q);
      end
      rdpid_pkg::STEP_INC: begin
        op_x = 28'(angle_rad);
        op_y = $signed({1'b0, time_step});
      end
      rdpid_pkg::STEP_ACC: begin
        op_x = 28'(roll_rate);
        op_y = 22'(rate_gain);
      end
      rdpid_pkg::STEP_T2: begin
        op_x = 28'(angle_rad);
        op_y = 22'(angle_gain);
      end
      rdpid_pkg::STEP_T3: begin
        op_x = integral;
        op_y = 22'(integral_gain);
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  // Rounding shifts; each result fits its slice
  assign ang_round = prod + 50'sd32768;
  assign inc_round = prod + 50'sd2048;
  assign inc       = inc_round[36:12];

  // Integrator update with symmetric clamp
  assign acc_sum = 29'(integral) + 29'(inc);
  assign lim     = $signed({3'b000, integral_limit, 12'h000});
  always_comb begin
    if (acc_sum > lim) begin
      acc_clamp = lim;
    end else if (acc_sum < -lim) begin
      acc_clamp = -lim;
    end else begin
      acc_clamp = acc_sum;
    end
  end

  // Pick the scaled gain term that the product holds
  always_comb begin
    case (cmd.step)
      rdpid_pkg::STEP_T2:  term = prod[33:10];
      rdpid_pkg::STEP_T3:  term = prod[35:12];
      rdpid_pkg::STEP_FIN: term = prod[43:20];
      default:             term = '0;
    endcase
  end

  // Clamp the damper term and add the pilot input
  always_comb begin
    if (dsum > 24'sd4500) begin
      damp = 14'(rdpid_pkg::DAMP_LIMIT);
    end else if (dsum < -24'sd4500) begin
      damp = -14'(rdpid_pkg::DAMP_LIMIT);
    end else begin
      damp = dsum[13:0];
    end
  end
  assign cmd_val = 15'(damp) + 15'(pilot);

  // Capture the transaction and run the arithmetic steps
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else begin
      if (cmd.load && (in_mode || !sts.in_active)) begin
        integral <= '0;
      end else if (cmd.step == rdpid_pkg::STEP_ACC) begin
        integral <= acc_clamp[27:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      active     <= sts.in_active;
      roll_rate  <= $signed(in_data[32:17]);
      roll_angle <= $signed(in_data[48:33]);
      pilot      <= $signed(in_data[62:49]);
      dsum       <= '0;
    end else if (cmd.step == rdpid_pkg::STEP_T2) begin
      dsum <= term;
    end else if (cmd.step == rdpid_pkg::STEP_T3 || cmd.step == rdpid_pkg::STEP_FIN) begin
      dsum <= dsum + term;
    end
    if (cmd.step == rdpid_pkg::STEP_ANG) begin
      angle_rad <= ang_round[31:16];
    end
    if (cmd.step != rdpid_pkg::STEP_NONE) begin
      prod <= op_x * op_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {active, cmd_val};
    end
  end

endmodule

// ===== rtl/roll_damper_pid_top.sv =====
// Channel    | Signals                          | Transaction
// input      | s_tvalid s_tready s_tdata s_tuser| one control tick
// output     | m_tvalid m_tready m_tdata        | one aileron result
// config     | cfg_we cfg_index cfg_data        | one register write
//
// An active tick (valid airspeed >= 1000 cm/s) passes CONV, ANG, INC, ACC, T2,
// T3, FIN and DONE up to the output register load; the single multiplier is
// used five times (angle scale, integrator step, three gain terms). An inactive
// tick goes straight to DONE; each load returns to IDLE for the next tick.
// Reset (rst, synchronous) restores register defaults and clears the integrator.
// A new tick is accepted while a result waits in the output register; a stalled
// output holds the finished tick in its last state until the register frees.
//
// Top level of the roll damper PID block. Depends on rdpid_pkg, rdpid_ctrl
// and rdpid_dp.
module roll_damper_pid_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [0] speed_valid, [16:1] airspeed, [32:17] roll_rate, [48:33] roll_angle,
  // [62:49] pilot_aileron, [63] zero
  input  logic [rdpid_pkg::IN_W-1:0]   s_tdata,
  // [0] mode
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [14:0] aileron_cmd, [15] damper_active
  output logic [rdpid_pkg::OUT_W-1:0]  m_tdata,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [rdpid_pkg::CFG_W-1:0]  cfg_data
);

  rdpid_pkg::dp_cmd_t cmd;
  rdpid_pkg::dp_sts_t sts;

  rdpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdpid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_mode   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // An accepted transaction keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accepting a tick");

  // A result is loaded only when the output register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending output");

  // Output valid rises only from a result load
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

endmodule

// ===== tb/roll_damper_pid_top_tb.sv =====
// Self-checking testbench for roll_damper_pid_top: directed ticks, then random tick runs
// under six register settings, checked against a fixed-point roll damper predictor.
// Depends on rdpid_pkg and roll_damper_pid_top.
module roll_damper_pid_top_tb;

  localparam int          N_DIRECTED      = 20;
  localparam int          N_PHASES        = 6;
  localparam int          ITEMS_PER_PHASE = 158;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          SETTLE_CYCLES   = 30;
  // Indexes with no register behind them
  localparam logic [2:0]  REG_SPARE       = 3'd5;
  localparam logic [2:0]  REG_TOP_SPARE   = 3'd7;

  // One control tick as carried on the input stream
  typedef struct packed {
    logic               mode;
    logic               speed_valid;
    logic [15:0]        airspeed;
    logic signed [15:0] roll_rate;
    logic signed [15:0] roll_angle;
    logic signed [13:0] pilot;
  } tick_t;

  // One aileron result as carried on the output stream
  typedef struct packed {
    logic signed [14:0] cmd;
    logic               active;
  } cmd_result_t;

  typedef struct packed {
    tick_t       tick;
    logic        has_fixed;
    cmd_result_t fixed;
  } directed_row_t;

  // Directed ticks under reset settings; fixed results only where they are obvious
  localparam directed_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    // gated off by speed_valid, every field at its top
    '{'{1'b0, 1'b0, 16'd65535, 32767, 18000, 4500}, 1'b1, '{4500, 1'b0}},
    // one below the airspeed threshold
    '{'{1'b0, 1'b1, 16'd999, -32768, -18000, -4500}, 1'b1, '{-4500, 1'b0}},
    // exactly at the threshold, mode entry, all zero
    '{'{1'b1, 1'b1, 16'd1000, 0, 0, 0}, 1'b1, '{0, 1'b1}},
    // rate term saturates the damper both ways, pilot at both extremes
    '{'{1'b0, 1'b1, 16'd1000, 32767, 0, 0}, 1'b1, '{-4500, 1'b1}},
    '{'{1'b0, 1'b1, 16'd65535, -32768, 0, 4500}, 1'b1, '{9000, 1'b1}},
    '{'{1'b0, 1'b1, 16'd40000, 32767, 0, -4500}, 1'b1, '{-9000, 1'b1}},
    // inactive, pilot beyond its range
    '{'{1'b0, 1'b0, 16'd0, 0, 0, -8192}, 1'b1, '{-8192, 1'b0}},
    '{'{1'b0, 1'b1, 16'd0, 0, 0, 8191}, 1'b1, '{8191, 1'b0}},
    // build up the integrator, then mode entry in the middle of it
    '{'{1'b0, 1'b1, 16'd3000, 0, 18000, 0}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'd3000, 0, 18000, 0}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'd3000, 100, 18000, 0}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'd3000, 0, -18000, 0}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'd3000, 0, -18000, 0}, 1'b0, '0},
    // angle beyond its range
    '{'{1'b0, 1'b1, 16'd3000, 0, 32767, 0}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'd3000, 0, -32768, 0}, 1'b0, '0},
    // rounding of tiny negative and positive values
    '{'{1'b0, 1'b1, 16'd1000, -1, -1, 8191}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'd1000, 1, 1, -8192}, 1'b0, '0},
    // invalid airspeed clears the integrator, then start again from zero
    '{'{1'b0, 1'b0, 16'd1000, 0, 18000, 0}, 1'b1, '{0, 1'b0}},
    '{'{1'b0, 1'b1, 16'd1000, 0, 18000, 0}, 1'b0, '0},
    // mode entry on an inactive tick
    '{'{1'b1, 1'b0, 16'd2000, 5, 5, 17}, 1'b1, '{17, 1'b0}}
  };

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [rdpid_pkg::IN_W-1:0]     s_tdata   = '0;
  logic                           s_tuser   = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [rdpid_pkg::OUT_W-1:0]    m_tdata;
  logic                           cfg_we    = 1'b0;
  logic [2:0]                     cfg_index = '0;
  logic [rdpid_pkg::CFG_W-1:0]    cfg_data  = '0;

  // Predictor copy of the registers and the integrator
  logic signed [13:0]  rate_gain_r     = -14'sd3200;
  logic signed [12:0]  angle_gain_r    = -13'sd800;
  logic signed [9:0]   integ_gain_r    = -10'sd200;
  logic [13:0]         integ_limit_r   = 14'd3072;
  logic [20:0]         time_step_r     = 21'd2621;
  int                  angle_integ_q20 = 0;

  cmd_result_t         cmd_expect_q [$];
  cmd_result_t         head_res;
  int                  fail_count       = 0;
  int                  cycle_count      = 0;
  int                  send_idle_pct    = 0;
  int                  recv_idle_pct    = 0;
  int                  ticks_sent       = 0;
  int                  active_ticks     = 0;
  int                  damp_clamped     = 0;
  int                  integ_at_bound   = 0;
  int                  mode_entries     = 0;
  int                  settings_applied = 0;

  roll_damper_pid_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Throttle the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cmd_expect_q.size() == 0) begin
        $error("result with no tick pending: aileron_cmd %0d damper_active %0d",
               $signed(m_tdata[14:0]), m_tdata[15]);
        fail_count++;
      end else begin
        head_res = cmd_expect_q.pop_front();
        if (m_tdata[14:0] !== head_res.cmd) begin
          $error("aileron_cmd: expected %0d, got %0d", head_res.cmd,
                 $signed(m_tdata[14:0]));
          fail_count++;
        end
        if (m_tdata[15] !== head_res.active) begin
          $error("damper_active: expected %0d, got %0d", head_res.active, m_tdata[15]);
          fail_count++;
        end
      end
    end
  end

  // Advance the damper by one tick and return the aileron command it gives
  function automatic cmd_result_t roll_cmd_predict(input tick_t t);
    longint      ang_rad;
    longint      lim;
    longint      step_inc;
    longint      integ;
    longint      damp;
    longint      cmd;
    logic        active;
    cmd_result_t r;
    active = t.speed_valid && (t.airspeed >= rdpid_pkg::MIN_AIRSPEED);
    damp = 0;
    if (t.mode) begin
      angle_integ_q20 = 0;
      mode_entries++;
    end
    if (active) begin
      // centidegrees to radians Q12, then the integrator step in Q20
      ang_rad = (longint'($signed(t.roll_angle)) * longint'(rdpid_pkg::ANGLE_TO_RAD_Q)
                 + 32768) >>> 16;
      lim = longint'(integ_limit_r) << 12;
      step_inc = (ang_rad * longint'(time_step_r) + 2048) >>> 12;
      integ = longint'(angle_integ_q20) + step_inc;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      if (lim != 0 && (integ == lim || integ == -lim)) integ_at_bound++;
      angle_integ_q20 = int'(integ);
      // three gain terms, each floored on its own
      damp = ((longint'(rate_gain_r) * longint'($signed(t.roll_rate))) >>> 10)
           + ((longint'(angle_gain_r) * ang_rad) >>> 12)
           + ((longint'(integ_gain_r) * integ) >>> 20);
      if (damp > rdpid_pkg::DAMP_LIMIT || damp < -rdpid_pkg::DAMP_LIMIT) damp_clamped++;
      if (damp > rdpid_pkg::DAMP_LIMIT) damp = rdpid_pkg::DAMP_LIMIT;
      if (damp < -rdpid_pkg::DAMP_LIMIT) damp = -rdpid_pkg::DAMP_LIMIT;
      active_ticks++;
    end else begin
      angle_integ_q20 = 0;
    end
    cmd = damp + longint'($signed(t.pilot));
    r.cmd = cmd[14:0];
    r.active = active;
    return r;
  endfunction

  // Offer one tick, hold it until accepted, then queue its expected result
  task automatic send_tick(input tick_t t, input logic has_fixed, input cmd_result_t fixed);
    cmd_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, t.pilot, t.roll_angle, t.roll_rate, t.airspeed, t.speed_valid};
    s_tuser  <= t.mode;
    do @(posedge clk); while (!s_tready);
    res = roll_cmd_predict(t);
    cmd_expect_q.push_back(has_fixed ? fixed : res);
    ticks_sent++;
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [2:0] idx, input longint val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[rdpid_pkg::CFG_W-1:0];
    case (idx)
      rdpid_pkg::REG_RATE_GAIN:      rate_gain_r   = val[13:0];
      rdpid_pkg::REG_ANGLE_GAIN:     angle_gain_r  = val[12:0];
      rdpid_pkg::REG_INTEGRAL_GAIN:  integ_gain_r  = val[9:0];
      rdpid_pkg::REG_INTEGRAL_LIMIT: integ_limit_r = val[13:0];
      rdpid_pkg::REG_TIME_STEP:      time_step_r   = val[20:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load a full register setting, with stray writes to unmapped indexes around it
  task automatic apply_settings(input longint rate_g, input longint angle_g,
                                input longint integ_g, input longint integ_lim,
                                input longint step);
    write_reg(REG_SPARE, longint'($urandom));
    write_reg(rdpid_pkg::REG_RATE_GAIN, rate_g);
    write_reg(rdpid_pkg::REG_ANGLE_GAIN, angle_g);
    write_reg(rdpid_pkg::REG_INTEGRAL_GAIN, integ_g);
    write_reg(rdpid_pkg::REG_INTEGRAL_LIMIT, integ_lim);
    write_reg(rdpid_pkg::REG_TIME_STEP, step);
    write_reg(REG_TOP_SPARE, longint'($urandom));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  initial begin : stimulus
    tick_t t;
    int    phase;
    int    n;
    int    k;
    int    run_len;
    int    bias;
    int    ang;
    int    drain_at;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks under reset settings
    send_idle_pct = 24;
    recv_idle_pct = 78;
    for (n = 0; n < N_DIRECTED; n++) begin
      send_tick(DIRECTED_ROWS[n].tick, DIRECTED_ROWS[n].has_fixed, DIRECTED_ROWS[n].fixed);
    end
    s_tvalid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);

    for (phase = 1; phase <= N_PHASES; phase++) begin
      // idle mostly on the result side, then mostly on the tick side, then not at all
      if (phase <= 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 78;
      end else if (phase <= 4) begin
        send_idle_pct = 78;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase)
        1: apply_settings(-5000, -3000, -500, 12800, 1048576);
        2: apply_settings(0, 0, 0, 0, 1);
        3: apply_settings(8191, -4096, 511, 16383, 2097151);
        4: apply_settings(-longint'($urandom_range(5000)), -longint'($urandom_range(3000)),
                          -longint'($urandom_range(500)), longint'($urandom_range(12800)),
                          longint'($urandom_range(1048576, 1)));
        5: apply_settings(-8192, 4095, -512, 1, 0);
        default: apply_settings(longint'($urandom), longint'($urandom), longint'($urandom),
                                longint'($urandom), longint'($urandom));
      endcase

      drain_at = int'($urandom_range(ITEMS_PER_PHASE - 20, 20));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        // a run of ticks around one roll attitude, so the integrator winds up
        run_len = int'($urandom_range(40, 4));
        bias = int'($urandom_range(36000)) - 18000;
        for (k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
          if ($urandom_range(99) < 10) begin
            t.mode        = 1'($urandom);
            t.speed_valid = 1'($urandom);
            t.airspeed    = 16'($urandom);
            t.roll_rate   = 16'($urandom);
            t.roll_angle  = 16'($urandom);
            t.pilot       = 14'($urandom);
          end else begin
            t.mode        = (k == 0) && ($urandom_range(2) == 0);
            t.speed_valid = ($urandom_range(19) != 0);
            t.airspeed    = 16'($urandom_range(65535, 1000));
            if ($urandom_range(9) == 0) t.airspeed = 16'($urandom_range(1010, 990));
            ang = bias + int'($urandom_range(1000)) - 500;
            if (ang > 18000) ang = 18000;
            if (ang < -18000) ang = -18000;
            t.roll_angle  = 16'(ang);
            if ($urandom_range(3) == 0) t.roll_rate = 16'($urandom);
            else t.roll_rate = 16'(int'($urandom_range(8192)) - 4096);
            t.pilot       = 14'(int'($urandom_range(9000)) - 4500);
          end
          // hold off the tick side once per phase until every result is back
          if (n == drain_at) begin
            s_tvalid <= 1'b0;
            while (cmd_expect_q.size() != 0) @(posedge clk);
          end
          send_tick(t, 1'b0, '0);
          n++;
        end
      end
      s_tvalid <= 1'b0;
      while (cmd_expect_q.size() != 0) @(posedge clk);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d ticks across reset and %0d register settings; %0d mode entries.",
             ticks_sent, settings_applied, mode_entries);
    $display("Damper engaged on %0d ticks, clamped on %0d, integrator at its bound on %0d.",
             active_ticks, damp_clamped, integ_at_bound);
    if (fail_count == 0 && cmd_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
